@@ sv/llt_pkg.sv @@
// ============================================================================
// llt_pkg
// Shared constants and types for the linked list table.
// ============================================================================
package llt_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_INS_HEAD   = 4'd0,
        CMD_INS_TAIL   = 4'd1,
        CMD_INS_BEFORE = 4'd2,
        CMD_INS_AFTER  = 4'd3,
        CMD_DEL_HEAD   = 4'd4,
        CMD_DEL_TAIL   = 4'd5,
        CMD_DEL_MATCH  = 4'd6,
        CMD_SEARCH     = 4'd7,
        CMD_COUNT      = 4'd8,
        CMD_READOUT    = 4'd9
    } cmd_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

@@ sv/llt_ram.sv @@
// ============================================================================
// llt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module llt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/linked_list_table_core.sv @@
// ============================================================================
// linked_list_table_core
// Ordered list of signed words in RAM with next links and an in-use map.
// ============================================================================
// channel  dir  fields (lsb first)
// s_axis   in   tdata: cmd[3:0], new_value[35:4], target_value[67:36]
// m_axis   out  tdata: status, found, entries_now, item_value; tlast: last
//
// One command at a time. Insert head/tail, count and empty-list commands pass
// through accept and dispatch; delete head adds a link read. Match searches,
// tail delete and readout read one entry per S_WALK/S_WAIT pair (RAM read
// latency); insert before/after adds a state for the second link write.
// Free slot search scans the in-use map, lowest index first, combinationally.
// Reset clears the in-use map, head, tail and count; RAM contents are not
// cleared. Output beats hold while m_axis_tready is low.
module linked_list_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd, new_value, target_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status, found, entries_now, item_value
    output logic        m_axis_tlast   // last
);
    import llt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_WALK, S_WAIT, S_OUT} state_t;

    localparam logic [IDX_BITS-1:0] IDX_ZERO = '0;

    state_t                state_reg;
    logic [3:0]            cmd_reg;
    logic [VALUE_BITS-1:0] nv_reg, tv_reg;
    logic [IDX_BITS-1:0]   head_reg, tail_reg, cur_reg, prev_reg;
    logic                  has_prev_reg;
    logic [CNT_BITS-1:0]   count_reg, n_reg;
    logic [DEPTH-1:0]      used_reg;
    logic [IDX_BITS-1:0]   nv_idx_reg;
    logic                  match_hit;

    logic                  o_valid_reg, o_last_reg, o_found_reg;
    logic [1:0]            o_status_reg;
    logic [CNT_BITS-1:0]   o_cnt_reg;
    logic [31:0]           o_item_reg;

    // RAM ports
    logic                  v_we, l_we;
    logic [IDX_BITS-1:0]   v_waddr, l_waddr, rd_addr;
    logic [VALUE_BITS-1:0] v_wdata, v_rdata;
    logic [IDX_BITS-1:0]   l_wdata, l_rdata;

    llt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(rd_addr), .rdata(v_rdata));
    llt_ram #(.WIDTH(IDX_BITS), .DEPTH(DEPTH)) u_lnk (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(rd_addr), .rdata(l_rdata));

    // lowest free slot
    logic [IDX_BITS-1:0] free_idx;
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    logic empty, full, out_free;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign out_free = !o_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {6'd0, o_item_reg, o_cnt_reg, o_found_reg, o_status_reg};

    // read address: cur_reg during walk
    assign rd_addr = cur_reg;

    assign match_hit = (v_rdata == tv_reg);

    logic [CNT_BITS-1:0] cnt_dec;
    assign cnt_dec = count_reg - CNT_BITS'(1);

    // write port control, combinational from state
    always_comb
    begin
        v_we = 1'b0; v_waddr = free_idx; v_wdata = nv_reg;
        l_we = 1'b0; l_waddr = free_idx; l_wdata = '0;
        if (state_reg == S_DISPATCH && out_free)
        begin
            unique case (cmd_reg)
                CMD_INS_HEAD, CMD_INS_TAIL:
                begin
                    if (!full)
                    begin
                        v_we = 1'b1;
                        l_we = 1'b1;
                        l_waddr = (cmd_reg == CMD_INS_TAIL && !empty) ? tail_reg : free_idx;
                        l_wdata = (cmd_reg == CMD_INS_TAIL && !empty) ? free_idx :
                                  (empty ? IDX_ZERO : head_reg);
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_WAIT && out_free)
        begin
            // match found at cur_reg, l_rdata = link of cur
            unique case (cmd_reg)
                CMD_INS_BEFORE:
                begin
                    if (match_hit && !full)
                    begin
                        v_we = 1'b1;
                        l_we = 1'b1; l_waddr = free_idx; l_wdata = cur_reg;
                    end
                end
                CMD_INS_AFTER:
                begin
                    if (match_hit && !full)
                    begin
                        v_we = 1'b1;
                        l_we = 1'b1; l_waddr = free_idx; l_wdata = l_rdata;
                    end
                end
                CMD_DEL_MATCH:
                begin
                    if (match_hit && has_prev_reg)
                    begin
                        l_we = 1'b1; l_waddr = prev_reg; l_wdata = l_rdata;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_OUT)
        begin
            // second link write of insert before/after
            if (cmd_reg == CMD_INS_BEFORE && has_prev_reg)
            begin
                l_we = 1'b1; l_waddr = prev_reg; l_wdata = nv_idx_reg;
            end
            if (cmd_reg == CMD_INS_AFTER)
            begin
                l_we = 1'b1; l_waddr = cur_reg; l_wdata = nv_idx_reg;
            end
        end
    end

    logic [31:0] item_ext;
    assign item_ext = 32'(signed'(v_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            used_reg     <= '0;
            o_valid_reg  <= 1'b0;
            cmd_reg      <= '0;
            nv_reg       <= '0;
            tv_reg       <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            has_prev_reg <= 1'b0;
            n_reg        <= '0;
            o_last_reg   <= 1'b0;
            o_found_reg  <= 1'b0;
            o_status_reg <= '0;
            o_cnt_reg    <= '0;
            o_item_reg   <= '0;
            nv_idx_reg   <= '0;
        end
        else
        begin
            if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cmd_reg   <= s_axis_tdata[3:0];
                        nv_reg    <= s_axis_tdata[35:4];
                        tv_reg    <= s_axis_tdata[67:36];
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (out_free)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_last_reg   <= 1'b1;
                        o_found_reg  <= 1'b0;
                        o_item_reg   <= '0;
                        o_status_reg <= ST_OK;
                        o_cnt_reg    <= count_reg;
                        state_reg    <= S_IDLE;
                        cur_reg      <= head_reg;
                        has_prev_reg <= 1'b0;
                        n_reg        <= '0;
                        unique case (cmd_reg)
                            CMD_INS_HEAD, CMD_INS_TAIL:
                            begin
                                if (full)
                                begin
                                    o_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    used_reg[free_idx] <= 1'b1;
                                    count_reg <= count_reg + CNT_BITS'(1);
                                    o_cnt_reg <= count_reg + CNT_BITS'(1);
                                    if (empty || cmd_reg == CMD_INS_HEAD)
                                    begin
                                        head_reg <= free_idx;
                                    end
                                    if (empty || cmd_reg == CMD_INS_TAIL)
                                    begin
                                        tail_reg <= free_idx;
                                    end
                                end
                            end
                            CMD_INS_BEFORE, CMD_INS_AFTER, CMD_DEL_MATCH,
                            CMD_SEARCH, CMD_DEL_TAIL, CMD_READOUT:
                            begin
                                if (empty)
                                begin
                                    o_status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    o_valid_reg <= 1'b0;
                                    state_reg   <= S_WALK;
                                end
                            end
                            CMD_DEL_HEAD:
                            begin
                                if (empty)
                                begin
                                    o_status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    o_valid_reg <= 1'b0;
                                    state_reg   <= S_WALK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK:
                begin
                    // RAM read of cur_reg issued this cycle
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_free)
                    begin
                        o_last_reg   <= 1'b1;
                        o_found_reg  <= 1'b0;
                        o_item_reg   <= '0;
                        o_status_reg <= ST_OK;
                        o_cnt_reg    <= count_reg;
                        state_reg    <= S_IDLE;
                        unique case (cmd_reg)
                            CMD_DEL_HEAD:
                            begin
                                o_valid_reg <= 1'b1;
                                used_reg[head_reg] <= 1'b0;
                                count_reg <= cnt_dec;
                                o_cnt_reg <= cnt_dec;
                                head_reg  <= (cnt_dec == '0) ? IDX_ZERO : l_rdata;
                                if (cnt_dec == '0)
                                begin
                                    tail_reg <= '0;
                                end
                            end
                            CMD_DEL_TAIL:
                            begin
                                // stop at entry count-2 (or immediately if one entry)
                                if (count_reg == CNT_BITS'(1) ||
                                    n_reg + CNT_BITS'(2) >= count_reg)
                                begin
                                    o_valid_reg <= 1'b1;
                                    used_reg[tail_reg] <= 1'b0;
                                    count_reg <= cnt_dec;
                                    o_cnt_reg <= cnt_dec;
                                    tail_reg  <= (cnt_dec == '0) ? IDX_ZERO : cur_reg;
                                    if (cnt_dec == '0)
                                    begin
                                        head_reg <= '0;
                                    end
                                end
                                else
                                begin
                                    cur_reg   <= l_rdata;
                                    n_reg     <= n_reg + CNT_BITS'(1);
                                    state_reg <= S_WALK;
                                end
                            end
                            CMD_READOUT:
                            begin
                                o_valid_reg <= 1'b1;
                                o_item_reg  <= item_ext;
                                if (n_reg + CNT_BITS'(1) == count_reg)
                                begin
                                    o_last_reg <= 1'b1;
                                end
                                else
                                begin
                                    o_last_reg <= 1'b0;
                                    cur_reg    <= l_rdata;
                                    n_reg      <= n_reg + CNT_BITS'(1);
                                    state_reg  <= S_WALK;
                                end
                            end
                            default:
                            begin
                                // match walk
                                if (match_hit)
                                begin
                                    o_valid_reg <= 1'b1;
                                    o_found_reg <= 1'b1;
                                    unique case (cmd_reg)
                                        CMD_INS_BEFORE, CMD_INS_AFTER:
                                        begin
                                            if (full)
                                            begin
                                                o_status_reg <= ST_FULL;
                                            end
                                            else
                                            begin
                                                used_reg[free_idx] <= 1'b1;
                                                nv_idx_reg <= free_idx;
                                                count_reg  <= count_reg + CNT_BITS'(1);
                                                o_cnt_reg  <= count_reg + CNT_BITS'(1);
                                                if (cmd_reg == CMD_INS_BEFORE)
                                                begin
                                                    if (!has_prev_reg)
                                                    begin
                                                        head_reg <= free_idx;
                                                    end
                                                end
                                                else if (cur_reg == tail_reg)
                                                begin
                                                    tail_reg <= free_idx;
                                                end
                                                o_valid_reg <= 1'b0;
                                                state_reg   <= S_OUT;
                                            end
                                        end
                                        CMD_DEL_MATCH:
                                        begin
                                            used_reg[cur_reg] <= 1'b0;
                                            count_reg <= cnt_dec;
                                            o_cnt_reg <= cnt_dec;
                                            if (!has_prev_reg)
                                            begin
                                                head_reg <= l_rdata;
                                            end
                                            if (cur_reg == tail_reg && has_prev_reg)
                                            begin
                                                tail_reg <= prev_reg;
                                            end
                                            if (cnt_dec == '0)
                                            begin
                                                head_reg <= '0;
                                                tail_reg <= '0;
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                                else if (n_reg + CNT_BITS'(1) >= count_reg)
                                begin
                                    o_valid_reg  <= 1'b1;
                                    o_status_reg <= ST_NOTFOUND;
                                end
                                else
                                begin
                                    prev_reg     <= cur_reg;
                                    has_prev_reg <= 1'b1;
                                    cur_reg      <= l_rdata;
                                    n_reg        <= n_reg + CNT_BITS'(1);
                                    state_reg    <= S_WALK;
                                end
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    // second link write done this cycle; output still free
                    o_valid_reg  <= 1'b1;
                    o_last_reg   <= 1'b1;
                    o_found_reg  <= 1'b1;
                    o_status_reg <= ST_OK;
                    o_item_reg   <= '0;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/llt_checker.sv @@
// ============================================================================
// llt_checker
// Port-level checks of the linked list table, bound to the top level.
// ============================================================================
module llt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import llt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped while stalled");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:3] <= 7'(DEPTH))
        else $error("entry count above depth");

    a_full_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_NOTFOUND |-> !m_axis_tdata[2])
        else $error("not found with found flag");

    a_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] == ST_OK)
        else $error("non-final beat outside readout");

endmodule

bind linked_list_table_core llt_checker u_llt_checker (.*);
